FILE: design/euler_to_quaternion_core_assert.svh
// Assertion macros used by the euler to quaternion design
`ifndef EULER_TO_QUATERNION_CORE_ASSERT_SVH
`define EULER_TO_QUATERNION_CORE_ASSERT_SVH

// Same-cycle implication, ignored while in reset
`define E2Q_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e2q assertion failed");

// Next-cycle implication, checked through reset
`define E2Q_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("e2q assertion failed");

`endif

FILE: design/e2q_pkg.sv
// Types, constants and tables for the euler to quaternion pipeline
package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int QUAT_WIDTH_DEF  = 16;

  localparam int ZFRAC        = 20;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int XY_W         = 32;
  localparam int Z_W          = 24;
  localparam int CS_W         = 18;
  localparam int CS_SHIFT     = 12;
  localparam int PAIR_W       = 2 * CS_W;
  localparam int TRIP_W       = 3 * CS_W;
  localparam int Q_W          = 27;
  localparam int Q_SHIFT      = 24;
  localparam int SUM_W        = 54;
  localparam int ROOT_W       = SUM_W / 2;
  localparam int COMB_LAT     = 5;

  localparam logic signed [Z_W-1:0]  HALF_PI_Z = 24'sd1647099;
  localparam logic signed [Z_W-1:0]  PI_Z      = 24'sd3294199;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd163008219;

  typedef logic signed [Q_W-1:0] comp_t;

  typedef struct packed {
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
  } sincos_t;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
    comp_t w;
  } quat_t;

  // Arctangent of 2^-idx in Q.20
  function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      0:       a = 24'sd823550;
      1:       a = 24'sd486170;
      2:       a = 24'sd256879;
      3:       a = 24'sd130396;
      4:       a = 24'sd65451;
      5:       a = 24'sd32757;
      6:       a = 24'sd16383;
      7:       a = 24'sd8192;
      8:       a = 24'sd4096;
      9:       a = 24'sd2048;
      10:      a = 24'sd1024;
      11:      a = 24'sd512;
      12:      a = 24'sd256;
      13:      a = 24'sd128;
      14:      a = 24'sd64;
      15:      a = 24'sd32;
      16:      a = 24'sd16;
      17:      a = 24'sd8;
      18:      a = 24'sd4;
      19:      a = 24'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: half-angle sine and cosine, one stage per step
module e2q_cordic #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::sincos_t              sc
);
  import e2q_pkg::*;

  localparam int FRAC   = ANGLE_WIDTH - 2;
  localparam int WIDE_W = ANGLE_WIDTH + ZFRAC;
  localparam logic signed [XY_W-1:0] RND = XY_W'(1) <<< (CS_SHIFT - 1);

  logic signed [WIDE_W-1:0] wide;
  logic signed [Z_W-1:0]    z_in;

  logic signed [Z_W-1:0]  z_r    [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r    [0:CORDIC_STEPS];
  logic                   flip_r [0:CORDIC_STEPS];

  logic signed [XY_W-1:0] xf, yf, xq, yq;
  sincos_t                sc_r;

  // Half angle in Q.20, floored where the source has more fraction bits
  assign wide = (WIDE_W'(angle) <<< ZFRAC) >>> FRAC;
  assign z_in = wide[Z_W-1:0];

  // Fold into +-pi/2
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      if (z_in > HALF_PI_Z) begin
        z_r[0]    <= z_in - PI_Z;
        flip_r[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Z) begin
        z_r[0]    <= z_in + PI_Z;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0]    <= z_in;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q20(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q20(i);
        end
      end
    end
  end

  // Undo the fold, then round Q.28 down to Q.16
  always_comb begin
    xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    xq = (xf + RND) >>> CS_SHIFT;
    yq = (yf + RND) >>> CS_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.c <= xq[CS_W-1:0];
      sc_r.s <= yq[CS_W-1:0];
    end
  end

  assign sc = sc_r;

endmodule

FILE: design/e2q_combine.sv
// Yaw-pitch-roll product, component rounding and sum of squares
module e2q_combine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  e2q_pkg::sincos_t rs,
  input  e2q_pkg::sincos_t ps,
  input  e2q_pkg::sincos_t ys,
  output logic             out_valid,
  output e2q_pkg::quat_t   q,
  output logic [e2q_pkg::SUM_W-1:0] sum
);
  import e2q_pkg::*;

  localparam int TW1 = TRIP_W + 1;
  localparam logic signed [TW1-1:0] QRND = TW1'(1) <<< (Q_SHIFT - 1);

  logic [COMB_LAT-1:0] valid_r;

  logic signed [PAIR_W-1:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [CS_W-1:0]   cy_r, sy_r;
  logic signed [TRIP_W-1:0] p_r [0:7];
  logic signed [TW1-1:0]    t0, t1, t2, t3;
  quat_t                    qc_r, qd_r, qe_r;
  logic signed [SUM_W-1:0]  sq_r [0:3];
  logic [SUM_W-1:0]         sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[COMB_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // roll-pitch pairs
      cc_r <= rs.c * ps.c;
      ss_r <= rs.s * ps.s;
      sc_r <= rs.s * ps.c;
      cs_r <= rs.c * ps.s;
      cy_r <= ys.c;
      sy_r <= ys.s;
      // triple products, exact in Q.48
      p_r[0] <= cc_r * cy_r;
      p_r[1] <= ss_r * sy_r;
      p_r[2] <= sc_r * cy_r;
      p_r[3] <= cs_r * sy_r;
      p_r[4] <= cs_r * cy_r;
      p_r[5] <= sc_r * sy_r;
      p_r[6] <= cc_r * sy_r;
      p_r[7] <= ss_r * cy_r;
    end
  end

  always_comb begin
    t0 = (TW1'(p_r[0]) + TW1'(p_r[1]) + QRND) >>> Q_SHIFT;
    t1 = (TW1'(p_r[2]) - TW1'(p_r[3]) + QRND) >>> Q_SHIFT;
    t2 = (TW1'(p_r[4]) + TW1'(p_r[5]) + QRND) >>> Q_SHIFT;
    t3 = (TW1'(p_r[6]) - TW1'(p_r[7]) + QRND) >>> Q_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qc_r.w <= t0[Q_W-1:0];
      qc_r.x <= t1[Q_W-1:0];
      qc_r.y <= t2[Q_W-1:0];
      qc_r.z <= t3[Q_W-1:0];
      sq_r[0] <= qc_r.w * qc_r.w;
      sq_r[1] <= qc_r.x * qc_r.x;
      sq_r[2] <= qc_r.y * qc_r.y;
      sq_r[3] <= qc_r.z * qc_r.z;
      qd_r    <= qc_r;
      sum_r   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
      qe_r    <= qd_r;
    end
  end

  assign out_valid = valid_r[COMB_LAT-1];
  assign q         = qe_r;
  assign sum       = sum_r;

endmodule

FILE: design/e2q_isqrt.sv
// Pipelined integer square root, one root bit per stage, quaternion carried along
module e2q_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [e2q_pkg::SUM_W-1:0]  radicand,
  input  e2q_pkg::quat_t             in_q,
  output logic                       out_valid,
  output logic [e2q_pkg::ROOT_W-1:0] root,
  output e2q_pkg::quat_t             out_q
);
  import e2q_pkg::*;

  logic [ROOT_W-1:0] valid_r;
  logic [SUM_W-1:0]  v_r [0:ROOT_W-1];
  logic [SUM_W-1:0]  r_r [0:ROOT_W-1];
  quat_t             q_r [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[ROOT_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] v_cur, r_cur, trial;
    quat_t            q_cur;

    if (k == 0) begin : g_first
      assign v_cur = radicand;
      assign r_cur = '0;
      assign q_cur = in_q;
    end else begin : g_rest
      assign v_cur = v_r[k-1];
      assign r_cur = r_r[k-1];
      assign q_cur = q_r[k-1];
    end

    assign trial = r_cur + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_cur;
        if (v_cur >= trial) begin
          v_r[k] <= v_cur - trial;
          r_r[k] <= (r_cur >> 1) + BIT;
        end else begin
          v_r[k] <= v_cur;
          r_r[k] <= r_cur >> 1;
        end
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign root      = r_r[ROOT_W-1][ROOT_W-1:0];
  assign out_q     = q_r[ROOT_W-1];

endmodule

FILE: design/e2q_div_lane.sv
// Pipelined restoring divider for one component: round(mag * 2^F / norm)
module e2q_div_lane #(
  parameter int QUAT_WIDTH = e2q_pkg::QUAT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [e2q_pkg::Q_W-1:0]    mag,
  input  logic                       neg,
  input  logic [e2q_pkg::ROOT_W-1:0] divisor,
  output logic [QUAT_WIDTH-2:0]      quo,
  output logic                       out_neg
);
  import e2q_pkg::*;

  localparam int F     = QUAT_WIDTH - 2;
  localparam int QB    = F + 1;
  localparam int NUM_W = Q_W + F + 1;

  logic [NUM_W-1:0]  rem_r [0:F-1];
  logic [ROOT_W-1:0] n_r   [0:F-1];
  logic [QB-1:0]     quo_r [0:F];
  logic              neg_r [0:F];

  for (genvar k = 0; k <= F; k++) begin : g_step
    logic [NUM_W-1:0]  rem_cur, trial;
    logic [ROOT_W-1:0] n_cur;
    logic [QB-1:0]     quo_cur;
    logic              neg_cur, take;

    if (k == 0) begin : g_first
      // add half the divisor up front for round half away from zero
      assign rem_cur = (NUM_W'(mag) << F) + NUM_W'(divisor >> 1);
      assign n_cur   = divisor;
      assign quo_cur = '0;
      assign neg_cur = neg;
    end else begin : g_rest
      assign rem_cur = rem_r[k-1];
      assign n_cur   = n_r[k-1];
      assign quo_cur = quo_r[k-1];
      assign neg_cur = neg_r[k-1];
    end

    assign trial = NUM_W'(n_cur) << (F - k);
    assign take  = rem_cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k] <= neg_cur;
        quo_r[k] <= take ? (quo_cur | (QB'(1) << (F - k))) : quo_cur;
      end
    end

    if (k < F) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k]   <= n_cur;
          rem_r[k] <= take ? rem_cur - trial : rem_cur;
        end
      end
    end
  end

  assign quo     = quo_r[F];
  assign out_neg = neg_r[F];

endmodule

FILE: design/euler_to_quaternion_core.sv
// Euler angles (roll, pitch, yaw) to normalized quaternion, top level
//
// Input stream: in_tvalid/in_tready/in_tdata carries one attitude sample per
// request, three signed Q2.13 angles in radians. Output stream:
// out_tvalid/out_tready/out_tdata carries the unit quaternion, scalar part
// non-negative, all parts Q1.14 and limited to +-1.
// Throughput: one request per cycle unless the receiver stalls. Every stage
// is a register stage of a single pipeline: 22 CORDIC stages, 5 product and
// square stages, one root bit per stage in the square root (27), one prepare
// stage, one quotient bit per stage in the dividers (QUAT_WIDTH-1) and an
// output register.
// A stalled receiver freezes the whole pipeline: in_tready follows the
// output register's ability to move, so no request is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; nothing else is held.
module euler_to_quaternion_core #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int QUAT_WIDTH  = e2q_pkg::QUAT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // roll, pitch, yaw (lowest bit up), zero padded to bytes
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // scalar_part, vec_x, vec_y, vec_z (lowest bit up), zero padded to bytes
  output logic [((4*QUAT_WIDTH+6)/8)*8-1:0] out_tdata
);
  import e2q_pkg::*;

  localparam int F       = QUAT_WIDTH - 2;
  localparam int DIV_LAT = F + 1;
  localparam int OUT_W   = ((4 * QUAT_WIDTH + 6) / 8) * 8;
  localparam logic [QUAT_WIDTH-2:0]        LIM_W = (QUAT_WIDTH-1)'(1) << F;
  localparam logic signed [QUAT_WIDTH-1:0] LIM_S = QUAT_WIDTH'(1) <<< F;

  logic en;

  logic signed [ANGLE_WIDTH-1:0] roll, pitch, yaw;
  sincos_t                       rs, ps, ys;
  logic [CORDIC_LAT-1:0]         cv_r;

  logic              cb_valid, sq_valid;
  quat_t             cb_q, sq_q;
  logic [SUM_W-1:0]  cb_sum;
  logic [ROOT_W-1:0] sq_root;

  comp_t             lanes [0:3];
  logic              neg0;
  logic [Q_W-1:0]    mag_r [0:3];
  logic              sgn_r [0:3];
  logic [ROOT_W-1:0] root_r;
  logic              pv_r, pz_r;

  logic [DIV_LAT-1:0]    dv_r, dz_r;
  logic [QUAT_WIDTH-2:0] quo   [0:3];
  logic                  q_neg [0:3];
  logic [QUAT_WIDTH-2:0] sat   [0:3];

  logic                         out_valid_r;
  logic [QUAT_WIDTH-2:0]        out_w_r;
  logic signed [QUAT_WIDTH-1:0] out_x_r, out_y_r, out_z_r;

  // whole pipeline advances unless a finished result is held
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign roll  = in_tdata[ANGLE_WIDTH-1:0];
  assign pitch = in_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
  assign yaw   = in_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH];

  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_roll (
    .clk(clk), .en(en), .angle(roll), .sc(rs)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_pitch (
    .clk(clk), .en(en), .angle(pitch), .sc(ps)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_yaw (
    .clk(clk), .en(en), .angle(yaw), .sc(ys)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[CORDIC_LAT-2:0], in_tvalid};
    end
  end

  e2q_combine u_combine (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv_r[CORDIC_LAT-1]),
    .rs(rs), .ps(ps), .ys(ys),
    .out_valid(cb_valid), .q(cb_q), .sum(cb_sum)
  );

  e2q_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cb_valid),
    .radicand(cb_sum), .in_q(cb_q),
    .out_valid(sq_valid), .root(sq_root), .out_q(sq_q)
  );

  // Flip the whole quaternion when the scalar part is negative
  always_comb begin
    lanes[0] = sq_q.w;
    lanes[1] = sq_q.x;
    lanes[2] = sq_q.y;
    lanes[3] = sq_q.z;
    neg0     = sq_q.w[Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag_r[k] <= lanes[k][Q_W-1] ? Q_W'(-lanes[k]) : Q_W'(lanes[k]);
        sgn_r[k] <= neg0 ? (lanes[k] > 0) : lanes[k][Q_W-1];
      end
      root_r <= sq_root;
      pz_r   <= (sq_root == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      dv_r <= '0;
    end else if (en) begin
      pv_r <= sq_valid;
      dv_r <= {dv_r[DIV_LAT-2:0], pv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r <= {dz_r[DIV_LAT-2:0], pz_r};
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    e2q_div_lane #(.QUAT_WIDTH(QUAT_WIDTH)) u_div (
      .clk(clk), .en(en), .mag(mag_r[k]), .neg(sgn_r[k]), .divisor(root_r),
      .quo(quo[k]), .out_neg(q_neg[k])
    );
    assign sat[k] = (quo[k] > LIM_W) ? LIM_W : quo[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_r[DIV_LAT-1]) begin
        // degenerate norm: identity rotation
        out_w_r <= LIM_W;
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
      end else begin
        out_w_r <= sat[0];
        out_x_r <= q_neg[1] ? -QUAT_WIDTH'(sat[1]) : QUAT_WIDTH'(sat[1]);
        out_y_r <= q_neg[2] ? -QUAT_WIDTH'(sat[2]) : QUAT_WIDTH'(sat[2]);
        out_z_r <= q_neg[3] ? -QUAT_WIDTH'(sat[3]) : QUAT_WIDTH'(sat[3]);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_z_r, out_y_r, out_x_r, out_w_r});

`include "euler_to_quaternion_core_assert.svh"

  `E2Q_ASSERT_IMPL(a_scalar_limit, out_tvalid, out_w_r <= LIM_W)
  `E2Q_ASSERT_IMPL(a_vec_x_limit, out_tvalid, (out_x_r <= LIM_S) && (out_x_r >= -LIM_S))
  `E2Q_ASSERT_IMPL(a_stall_holds_input, !out_tready && out_tvalid, !in_tready)
  `E2Q_ASSERT_NEXT(a_reset_empties, !rst_n, !out_tvalid && (dv_r == '0))

endmodule
